>>> rtl/washer_manual_run_controller_top_macros.svh
// Assertion macros shared by the washer manual-run controller RTL.
`ifndef WASHER_MANUAL_RUN_CONTROLLER_TOP_MACROS_SVH
`define WASHER_MANUAL_RUN_CONTROLLER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define WMRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wmrc assertion failed");

// Check that cons holds in the cycle after ante.
`define WMRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wmrc assertion failed");

`endif

>>> rtl/wmrc_pkg.sv
// Package with codes and fixed constants of the washer manual-run controller.
package wmrc_pkg;

  localparam logic [7:0] LEVEL_DELAY      = 8'd10;
  localparam logic [7:0] TEMP_DELAY       = 8'd10;
  localparam logic [6:0] TICKS_PER_SECOND = 7'd50;
  localparam logic [15:0] SECONDS_MAX     = 16'hFFFF;

  typedef enum logic {
    OP_CTRL = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    CFG_LEVEL_THRESHOLD   = 3'd0,
    CFG_SOAP_START_LEVEL  = 3'd1,
    CFG_REFILL_DIFFERENCE = 3'd2,
    CFG_TEMP_THRESHOLD    = 3'd3,
    CFG_REHEAT_DIFFERENCE = 3'd4,
    CFG_WASH_RUN_SECONDS  = 3'd5,
    CFG_WASH_STOP_SECONDS = 3'd6,
    CFG_WASH_SPEED        = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    DIR_OFF = 2'd0,
    DIR_FWD = 2'd1,
    DIR_REV = 2'd2
  } motor_dir_t;

  typedef enum logic [1:0] {
    PHASE_FWD   = 2'd0,
    PHASE_STOP1 = 2'd1,
    PHASE_REV   = 2'd2,
    PHASE_STOP2 = 2'd3
  } motor_phase_t;

  typedef struct packed {
    logic       flag;
    logic [7:0] count;
  } debounce_t;

endpackage

>>> rtl/washer_manual_run_controller_top.sv
// Top level of the washer manual-run controller: input stage, control pass and result register.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_op .. in_want_*  | to block
//   out     | out_valid, out_stall, out_cold_valve .. | from block
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | to block
//
// One transaction per cycle when not stalled; a result passes the input and result registers.
// The input register feeds one compare/count pass that updates state into the result register.
// Synchronous active-low reset clears configuration, flags, counters and the held outputs.
// A stalled output holds its result; the input register then fills and in_stall rises.
// cfg_ready is always high; write configuration only while no transaction is in flight.

`include "washer_manual_run_controller_top_macros.svh"

module washer_manual_run_controller_top
  import wmrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_pressure,
  input  logic [7:0]  in_temperature,
  input  logic        in_paused,
  input  logic        in_want_wash,
  input  logic        in_want_cold,
  input  logic        in_want_hot,
  input  logic        in_want_supply_one,
  input  logic        in_want_supply_two,
  input  logic        in_want_supply_three,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_cold_valve,
  output logic        out_hot_valve,
  output logic [2:0]  out_soap_pumps,
  output logic [1:0]  out_motor_dir,
  output logic [7:0]  out_motor_speed,
  output logic        out_drain_close_req,
  output logic        out_level_reached_out,
  output logic        out_temp_reached_out,
  output logic [1:0]  out_motor_phase_out,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  function automatic debounce_t debounce(input logic flag, input logic [7:0] count,
                                         input logic cond, input logic [7:0] delay);
    debounce_t res;
    res.flag  = flag;
    res.count = 8'd0;
    if (cond) begin
      if (count == delay) begin
        res.flag  = ~flag;
      end else begin
        res.count = count + 8'd1;
      end
    end
    return res;
  endfunction

  // configuration registers
  logic [15:0] level_threshold_r, soap_start_level_r, refill_difference_r;
  logic [7:0]  temp_threshold_r, reheat_difference_r;
  logic [15:0] wash_run_seconds_r, wash_stop_seconds_r;
  logic [7:0]  wash_speed_r;

  // input stage
  logic        s1_valid_r;
  logic        s1_op_r;
  logic [15:0] s1_pressure_r;
  logic [7:0]  s1_temperature_r;
  logic        s1_paused_r, s1_wash_r, s1_cold_r, s1_hot_r;
  logic [2:0]  s1_supplies_r;

  // controller state; held outputs double as the result register
  logic        level_reached_r, level_reached_nxt;
  logic [7:0]  level_count_r, level_count_nxt;
  logic [7:0]  soap_count_r, soap_count_nxt;
  logic        temp_reached_r, temp_reached_nxt;
  logic [7:0]  temp_count_r, temp_count_nxt;
  logic [6:0]  tick_prescale_r, tick_prescale_nxt;
  logic [1:0]  motor_phase_r, motor_phase_nxt;
  logic [15:0] motor_seconds_r, motor_seconds_nxt;
  logic [15:0] motor_limit_r, motor_limit_nxt;
  logic        cold_r, cold_nxt, hot_r, hot_nxt;
  logic [2:0]  pumps_r, pumps_nxt;
  logic [1:0]  dir_r, dir_nxt;
  logic [7:0]  speed_r, speed_nxt;
  logic        drain_r, drain_nxt;
  logic        out_valid_r;

  logic        advance;
  logic        in_take;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // control pass and tick handling
  always_comb begin
    logic [15:0] level_low;
    logic [7:0]  temp_low;
    logic [6:0]  pre_inc;
    logic [1:0]  phase_adv;
    logic        soap_ready;
    debounce_t   lvl_db, tmp_db;

    level_reached_nxt = level_reached_r;
    level_count_nxt   = level_count_r;
    soap_count_nxt    = soap_count_r;
    temp_reached_nxt  = temp_reached_r;
    temp_count_nxt    = temp_count_r;
    tick_prescale_nxt = tick_prescale_r;
    motor_phase_nxt   = motor_phase_r;
    motor_seconds_nxt = motor_seconds_r;
    motor_limit_nxt   = motor_limit_r;
    cold_nxt          = cold_r;
    hot_nxt           = hot_r;
    pumps_nxt         = pumps_r;
    dir_nxt           = dir_r;
    speed_nxt         = speed_r;
    drain_nxt         = 1'b0;

    level_low = (level_threshold_r >= refill_difference_r) ?
                level_threshold_r - refill_difference_r : 16'd0;
    temp_low  = (temp_threshold_r >= reheat_difference_r) ?
                temp_threshold_r - reheat_difference_r : 8'd0;
    pre_inc   = tick_prescale_r + 7'd1;
    phase_adv = motor_phase_r + 2'd1;
    soap_ready = 1'b0;
    lvl_db    = '0;
    tmp_db    = '0;

    if (s1_op_r == OP_TICK) begin
      if (!s1_paused_r) begin
        tick_prescale_nxt = pre_inc;
        if (pre_inc >= TICKS_PER_SECOND) begin
          tick_prescale_nxt = 7'd0;
          if (s1_wash_r && motor_seconds_r < SECONDS_MAX) begin
            motor_seconds_nxt = motor_seconds_r + 16'd1;
          end
        end
      end else begin
        tick_prescale_nxt = 7'd0;
      end
    end else begin
      // level hysteresis; soap count follows the flag before this pass
      if (!level_reached_r) begin
        lvl_db = debounce(level_reached_r, level_count_r,
                          s1_pressure_r >= level_threshold_r, LEVEL_DELAY);
        if (s1_pressure_r >= soap_start_level_r) begin
          if (soap_count_r < LEVEL_DELAY) soap_count_nxt = soap_count_r + 8'd1;
        end else begin
          soap_count_nxt = 8'd0;
        end
      end else begin
        lvl_db = debounce(level_reached_r, level_count_r,
                          s1_pressure_r <= level_low, LEVEL_DELAY);
        soap_count_nxt = LEVEL_DELAY;
      end
      level_reached_nxt = lvl_db.flag;
      level_count_nxt   = lvl_db.count;

      if (!temp_reached_r) begin
        tmp_db = debounce(temp_reached_r, temp_count_r,
                          s1_temperature_r >= temp_threshold_r, TEMP_DELAY);
      end else begin
        tmp_db = debounce(temp_reached_r, temp_count_r,
                          s1_temperature_r <= temp_low, TEMP_DELAY);
      end
      temp_reached_nxt = tmp_db.flag;
      temp_count_nxt   = tmp_db.count;

      // advance the motor phase once its time is up
      if (motor_seconds_r >= motor_limit_r) begin
        motor_seconds_nxt = 16'd0;
        motor_phase_nxt   = phase_adv;
        motor_limit_nxt   = phase_adv[0] ? wash_stop_seconds_r : wash_run_seconds_r;
      end

      if (!s1_paused_r) begin
        soap_ready = soap_count_nxt >= LEVEL_DELAY;
        cold_nxt   = 1'b0;
        hot_nxt    = 1'b0;
        pumps_nxt  = 3'd0;
        dir_nxt    = DIR_OFF;
        speed_nxt  = 8'd0;
        if (!level_reached_nxt) begin
          cold_nxt = s1_cold_r || (s1_supplies_r != 3'd0 && !soap_ready);
          hot_nxt  = s1_hot_r;
          if (soap_ready) pumps_nxt = s1_supplies_r;
        end
        if (s1_wash_r) begin
          if (motor_phase_nxt == PHASE_FWD) begin
            dir_nxt = DIR_FWD;
          end else if (motor_phase_nxt == PHASE_REV) begin
            dir_nxt = DIR_REV;
          end
          speed_nxt = wash_speed_r;
        end else begin
          motor_seconds_nxt = 16'd0;
        end
        drain_nxt = s1_cold_r || s1_hot_r || (s1_supplies_r != 3'd0);
      end else begin
        // pause drops every held output
        cold_nxt  = 1'b0;
        hot_nxt   = 1'b0;
        pumps_nxt = 3'd0;
        dir_nxt   = DIR_OFF;
        speed_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_threshold_r   <= '0;
      soap_start_level_r  <= '0;
      refill_difference_r <= '0;
      temp_threshold_r    <= '0;
      reheat_difference_r <= '0;
      wash_run_seconds_r  <= '0;
      wash_stop_seconds_r <= '0;
      wash_speed_r        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_LEVEL_THRESHOLD:   level_threshold_r   <= cfg_data;
        CFG_SOAP_START_LEVEL:  soap_start_level_r  <= cfg_data;
        CFG_REFILL_DIFFERENCE: refill_difference_r <= cfg_data;
        CFG_TEMP_THRESHOLD:    temp_threshold_r    <= cfg_data[7:0];
        CFG_REHEAT_DIFFERENCE: reheat_difference_r <= cfg_data[7:0];
        CFG_WASH_RUN_SECONDS:  wash_run_seconds_r  <= cfg_data;
        CFG_WASH_STOP_SECONDS: wash_stop_seconds_r <= cfg_data;
        CFG_WASH_SPEED:        wash_speed_r        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r          <= in_op;
      s1_pressure_r    <= in_pressure;
      s1_temperature_r <= in_temperature;
      s1_paused_r      <= in_paused;
      s1_wash_r        <= in_want_wash;
      s1_cold_r        <= in_want_cold;
      s1_hot_r         <= in_want_hot;
      s1_supplies_r    <= {in_want_supply_three, in_want_supply_two, in_want_supply_one};
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_reached_r <= 1'b0;
      level_count_r   <= '0;
      soap_count_r    <= '0;
      temp_reached_r  <= 1'b0;
      temp_count_r    <= '0;
      tick_prescale_r <= '0;
      motor_phase_r   <= PHASE_FWD;
      motor_seconds_r <= '0;
      motor_limit_r   <= '0;
      cold_r          <= 1'b0;
      hot_r           <= 1'b0;
      pumps_r         <= '0;
      dir_r           <= DIR_OFF;
      speed_r         <= '0;
      drain_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (advance) begin
        level_reached_r <= level_reached_nxt;
        level_count_r   <= level_count_nxt;
        soap_count_r    <= soap_count_nxt;
        temp_reached_r  <= temp_reached_nxt;
        temp_count_r    <= temp_count_nxt;
        tick_prescale_r <= tick_prescale_nxt;
        motor_phase_r   <= motor_phase_nxt;
        motor_seconds_r <= motor_seconds_nxt;
        motor_limit_r   <= motor_limit_nxt;
        cold_r          <= cold_nxt;
        hot_r           <= hot_nxt;
        pumps_r         <= pumps_nxt;
        dir_r           <= dir_nxt;
        speed_r         <= speed_nxt;
        drain_r         <= drain_nxt;
        out_valid_r     <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r     <= 1'b0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_cold_valve        = cold_r;
  assign out_hot_valve         = hot_r;
  assign out_soap_pumps        = pumps_r;
  assign out_motor_dir         = dir_r;
  assign out_motor_speed       = speed_r;
  assign out_drain_close_req   = drain_r;
  assign out_level_reached_out = level_reached_r;
  assign out_temp_reached_out  = temp_reached_r;
  assign out_motor_phase_out   = motor_phase_r;

  `WMRC_ASSERT_NEXT(a_pause_clears, advance && s1_op_r == OP_CTRL && s1_paused_r,
    !cold_r && !hot_r && pumps_r == 3'd0 && dir_r == DIR_OFF && speed_r == 8'd0 && !drain_r)
  `WMRC_ASSERT_NEXT(a_tick_no_drain, advance && s1_op_r == OP_TICK, !drain_r)
  `WMRC_ASSERT_NOW(a_pumps_need_fill, pumps_r != 3'd0, !level_reached_r)
  `WMRC_ASSERT_NOW(a_prescale_range, 1'b1, tick_prescale_r < TICKS_PER_SECOND)
  `WMRC_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_r && out_valid_r)

endmodule
